@@ hw/rtl/per_mode_pot_pickup_mapper_core_defines.svh @@
// Assertion macros shared by the pot pickup mapper RTL.
`ifndef PER_MODE_POT_PICKUP_MAPPER_CORE_DEFINES_SVH
`define PER_MODE_POT_PICKUP_MAPPER_CORE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication.
`define PMPM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pickup mapper assertion failed");

// Next-cycle implication.
`define PMPM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pickup mapper assertion failed");

`else

`define PMPM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PMPM_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ hw/rtl/pmpm_pkg.sv @@
// Types, constants and mapping functions of the pot pickup mapper.
package pmpm_pkg;

  localparam int POT_BITS  = 16;
  localparam int Q_BITS    = 16;
  localparam int NUM_MODES = 3;
  localparam int NUM_POTS  = 4;

  localparam int POT_DECAY     = 0;
  localparam int POT_VOLUME    = 1;
  localparam int POT_DIRECTION = 2;
  localparam int POT_MIX       = 3;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_UP   = 2'd1;
  localparam logic [1:0] MODE_MID  = 2'd2;
  localparam logic [1:0] MODE_DOWN = 2'd3;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_IDX_THRESHOLD = 1'b0;
  localparam logic [15:0] THRESHOLD_RESET = 16'd655;

  localparam logic [16:0] Q16_ONE  = 17'd65536;
  localparam logic [15:0] Q16_HALF = 16'd32768;

  // ceil(2^21 / 5); exact floor division for numerators below 2^19
  localparam logic [18:0] RECIP5 = 19'd419431;

  localparam int S_TDATA_W = 64;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 88;

  typedef logic [Q_BITS-1:0] pot_t;
  typedef logic [16:0] gain_t;
  typedef pot_t [NUM_POTS-1:0] pot_row_t;

  function automatic pot_t pot_to_q16(input logic [15:0] raw);
    pot_t v;
    v = Q_BITS'(raw[POT_BITS-1:0]);
    return v << (Q_BITS - POT_BITS);
  endfunction

  function automatic gain_t map_wet(input pot_t x);
    return (x < Q16_HALF) ? {x, 1'b0} : Q16_ONE;
  endfunction

  function automatic gain_t map_dry(input pot_t x);
    logic [17:0] two;
    two = 18'd131072 - {1'b0, x, 1'b0};
    return (x < Q16_HALF) ? Q16_ONE : two[16:0];
  endfunction

  // x/5 up to half, else (65536 + 18(x - half))/10, both rounded to nearest
  function automatic gain_t map_volume(input pot_t x);
    logic [15:0] d;
    logic [20:0] hi;
    logic [18:0] num;
    logic [37:0] prod;
    d    = x - Q16_HALF;
    hi   = 21'd65541 + {1'b0, d, 4'b0} + {4'b0, d, 1'b0};
    num  = (x <= Q16_HALF) ? (19'(x) + 19'd2) : hi[19:1];
    prod = num * RECIP5;
    return prod[37:21];
  endfunction

endpackage

@@ hw/rtl/per_mode_pot_pickup_mapper_core.sv @@
// Per-mode pot pickup (soft takeover) mapper: top level.
//
// Input stream s_*: one control frame per transfer. s_tuser carries the
// mode switch, s_tdata the four pot readings (Q0.16, low POT_BITS used).
// Output stream m_*: one result per frame: decoded mode and the mapped
// wet/dry gains, direction, playback volume and overdub decay.
// A pot that is locked after a mode change keeps its last output until it
// moves more than pickup_threshold away from the reading stashed for that
// mode.
// The output is registered: a frame accepted at an edge is on m_tdata after
// that edge. One frame per cycle while m_tready stays high; the lock, stash
// and mapping logic sits between the input handshake and the output register.
// s_tready is high whenever the output register is empty or being drained,
// so a stalled receiver holds the result and back-pressures the input.
// Reset clears the mode history, lock flags, held outputs and output valid
// and restores pickup_threshold to 655; the stash needs no clearing.
// APB port: pickup_threshold at byte address 0, writes in the access cycle.
`include "per_mode_pot_pickup_mapper_core_defines.svh"

module per_mode_pot_pickup_mapper_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [15:0] decay_pot, [31:16] volume_pot, [47:32] direction_pot, [63:48] mix_pot
  input  logic [pmpm_pkg::S_TDATA_W-1:0]    s_tdata,
  // [0] switch_up, [1] switch_down
  input  logic [pmpm_pkg::S_TUSER_W-1:0]    s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [1:0] mode, [18:2] wet_level, [35:19] dry_level, [51:36] direction_value,
  // [68:52] play_level, [84:69] decay_level, [87:85] zero
  output logic [pmpm_pkg::M_TDATA_W-1:0]    m_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pmpm_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [pmpm_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [pmpm_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import pmpm_pkg::*;

  logic [15:0]        pickup_threshold;
  logic [1:0]         last_mode;
  pot_row_t           stash [NUM_MODES];
  logic [NUM_POTS-1:0] lock_flags [NUM_MODES];

  logic [1:0]         out_mode;
  gain_t              held_wet;
  gain_t              held_dry;
  pot_t               held_direction;
  gain_t              held_volume;
  pot_t               held_decay;

  logic               accept;
  logic [1:0]         mode;
  logic [1:0]         mode_idx;
  logic               mode_changed;
  pot_row_t           pots;
  pot_row_t           ref_row;
  logic [NUM_POTS-1:0] lock_base;
  logic [NUM_POTS-1:0] locks_next;
  pot_t               diff [NUM_POTS];

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IDX_THRESHOLD) ? CFG_DATA_W'(pickup_threshold)
                                                  : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pickup_threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == REG_IDX_THRESHOLD) begin
      pickup_threshold <= pwdata[15:0];
    end
  end

  // handshake: output register frees up when drained
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // mode decode, up has priority
  always_comb begin
    if (s_tuser[0]) begin
      mode = MODE_UP;
    end else if (s_tuser[1]) begin
      mode = MODE_DOWN;
    end else begin
      mode = MODE_MID;
    end
  end

  assign mode_idx     = mode - 2'd1;
  assign mode_changed = (mode != last_mode);

  always_comb begin
    for (int i = 0; i < NUM_POTS; i++) begin
      pots[i] = pot_to_q16(s_tdata[16*i +: 16]);
    end
  end

  // a mode change stashes the live readings and locks every pot
  assign ref_row   = mode_changed ? pots : stash[mode_idx];
  assign lock_base = mode_changed ? {NUM_POTS{1'b1}} : lock_flags[mode_idx];

  always_comb begin
    for (int i = 0; i < NUM_POTS; i++) begin
      diff[i] = (pots[i] > ref_row[i]) ? (pots[i] - ref_row[i])
                                       : (ref_row[i] - pots[i]);
      locks_next[i] = lock_base[i] && !(diff[i] > pickup_threshold);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && mode_changed) begin
      stash[mode_idx] <= pots;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_mode <= MODE_NONE;
      for (int k = 0; k < NUM_MODES; k++) begin
        lock_flags[k] <= '0;
      end
      m_tvalid       <= 1'b0;
      out_mode       <= MODE_NONE;
      held_wet       <= '0;
      held_dry       <= '0;
      held_direction <= '0;
      held_volume    <= '0;
      held_decay     <= '0;
    end else begin
      if (accept) begin
        last_mode            <= mode;
        lock_flags[mode_idx] <= locks_next;
        out_mode             <= mode;
        if (!locks_next[POT_MIX]) begin
          held_wet <= map_wet(pots[POT_MIX]);
          held_dry <= map_dry(pots[POT_MIX]);
        end
        if (!locks_next[POT_DIRECTION]) begin
          held_direction <= pots[POT_DIRECTION];
        end
        if (!locks_next[POT_VOLUME]) begin
          held_volume <= map_volume(pots[POT_VOLUME]);
        end
        if (!locks_next[POT_DECAY]) begin
          held_decay <= pots[POT_DECAY];
        end
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {3'b000, held_decay, held_volume, held_direction,
                    held_dry, held_wet, out_mode};

  `PMPM_ASSERT_NEXT(a_accept_gives_result, clk, rst, accept, m_tvalid)
  `PMPM_ASSERT_IMP(a_no_overwrite, clk, rst, m_tvalid && !m_tready, !s_tready)
  `PMPM_ASSERT_NEXT(a_change_locks_all, clk, rst, accept && mode_changed,
                    lock_flags[$past(mode_idx)] == {NUM_POTS{1'b1}})
  `PMPM_ASSERT_IMP(a_result_mode_valid, clk, rst, m_tvalid, out_mode != MODE_NONE)

endmodule

@@ tb/sv/per_mode_pot_pickup_mapper_core_tb.sv @@
// Self-checking testbench of the per-mode pot pickup mapper core.
`timescale 1ns / 100ps

module per_mode_pot_pickup_mapper_core_tb;
  import pmpm_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] THRESHOLD_ADDR = CFG_ADDR_W'(4 * REG_IDX_THRESHOLD);
  localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR  = CFG_ADDR_W'(4);
  localparam int PHASES       = 10;
  localparam int PHASE_FRAMES = 150;

  typedef struct packed {
    logic        up;
    logic        down;
    logic [15:0] decay;
    logic [15:0] volume;
    logic [15:0] direction;
    logic [15:0] mix;
  } frame_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [16:0] wet;
    logic [16:0] dry;
    logic [15:0] direction;
    logic [16:0] volume;
    logic [15:0] decay;
  } mapped_t;

  typedef struct packed {
    frame_t  f;
    logic    typed;
    mapped_t want;
  } frame_row_t;

  logic                  clk;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata  = '0;
  logic [S_TUSER_W-1:0]  s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr    = '0;
  logic [CFG_DATA_W-1:0] pwdata   = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  per_mode_pot_pickup_mapper_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Mapper state as the block should hold it
  logic [15:0] threshold  = THRESHOLD_RESET;
  logic [1:0]  seen_mode  = MODE_NONE;
  int unsigned stash [NUM_MODES][NUM_POTS];
  logic [3:0]  pot_locks [NUM_MODES] = '{default: 4'h0};
  logic [16:0] held_wet    = '0;
  logic [16:0] held_dry    = '0;
  logic [15:0] held_dir    = '0;
  logic [16:0] held_volume = '0;
  logic [15:0] held_decay  = '0;

  mapped_t pending_maps [$];
  int      fail_count = 0;
  bit      no_gaps    = 1'b0;

  // Random walk of the four knobs and the switch position
  int unsigned knob [NUM_POTS] = '{default: 32768};
  logic [1:0]  switch_pos = 2'b00;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned scale_pot(input logic [15:0] raw);
    int unsigned mask;
    mask = (1 << POT_BITS) - 1;
    return (int'(raw) & mask) << (16 - POT_BITS);
  endfunction

  function automatic mapped_t map_frame(input frame_t f);
    logic [1:0]  mode;
    int unsigned pots [NUM_POTS];
    int unsigned m;
    int unsigned diff;
    int unsigned x;
    mapped_t     r;
    mode = f.up ? MODE_UP : (f.down ? MODE_DOWN : MODE_MID);
    pots[POT_DECAY]     = scale_pot(f.decay);
    pots[POT_VOLUME]    = scale_pot(f.volume);
    pots[POT_DIRECTION] = scale_pot(f.direction);
    pots[POT_MIX]       = scale_pot(f.mix);
    m = mode - 1;
    // mode change: stash live readings and lock every pot of the new mode
    if (mode != seen_mode) begin
      for (int i = 0; i < NUM_POTS; i++) stash[m][i] = pots[i];
      pot_locks[m] = 4'hF;
    end
    seen_mode = mode;
    for (int i = 0; i < NUM_POTS; i++) begin
      diff = (pots[i] > stash[m][i]) ? pots[i] - stash[m][i] : stash[m][i] - pots[i];
      if (diff > threshold) pot_locks[m][i] = 1'b0;
    end
    if (!pot_locks[m][POT_MIX]) begin
      x = pots[POT_MIX];
      held_wet = (x < 32768) ? 17'(2 * x) : 17'(65536);
      held_dry = (x < 32768) ? 17'(65536) : 17'(131072 - 2 * x);
    end
    if (!pot_locks[m][POT_DIRECTION]) held_dir = 16'(pots[POT_DIRECTION]);
    if (!pot_locks[m][POT_VOLUME]) begin
      x = pots[POT_VOLUME];
      held_volume = (x <= 32768) ? 17'((x + 2) / 5)
                                 : 17'((65536 + 18 * (x - 32768) + 5) / 10);
    end
    if (!pot_locks[m][POT_DECAY]) held_decay = 16'(pots[POT_DECAY]);
    r.mode      = mode;
    r.wet       = held_wet;
    r.dry       = held_dry;
    r.direction = held_dir;
    r.volume    = held_volume;
    r.decay     = held_decay;
    return r;
  endfunction

  // Well-formed knob sweeps with occasional switch moves, plus raw noise
  function automatic frame_t random_frame();
    frame_t      f;
    int          spread;
    int          v;
    int unsigned pick;
    if ($urandom_range(0, 9) == 0) begin
      f.up        = 1'($urandom_range(0, 1));
      f.down      = 1'($urandom_range(0, 1));
      f.decay     = 16'($urandom_range(0, 65535));
      f.volume    = 16'($urandom_range(0, 65535));
      f.direction = 16'($urandom_range(0, 65535));
      f.mix       = 16'($urandom_range(0, 65535));
      return f;
    end
    if ($urandom_range(0, 9) == 0) switch_pos = 2'($urandom_range(0, 3));
    for (int i = 0; i < NUM_POTS; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        spread = ($urandom_range(0, 3) == 0) ? 4000 : 1000;
        v = int'(knob[i]) + int'($urandom_range(0, 2 * spread)) - spread;
        knob[i] = (v < 0) ? 0 : ((v > 65535) ? 65535 : v);
      end else if (pick < 8) begin
        knob[i] = $urandom_range(0, 65535);
      end
    end
    f.up        = switch_pos[0];
    f.down      = switch_pos[1];
    f.decay     = 16'(knob[POT_DECAY]);
    f.volume    = 16'(knob[POT_VOLUME]);
    f.direction = 16'(knob[POT_DIRECTION]);
    f.mix       = 16'(knob[POT_MIX]);
    return f;
  endfunction

  task automatic send_frame(input frame_t f, input logic typed, input mapped_t want);
    int      gap;
    mapped_t predicted;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {f.mix, f.direction, f.volume, f.decay};
    s_tuser  <= {f.down, f.up};
    do @(posedge clk); while (!s_tready);
    predicted = map_frame(f);
    pending_maps.push_back(typed ? want : predicted);
  endtask

  // Drop valid and let every pending result drain
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic program_threshold(input logic [CFG_ADDR_W-1:0] addr,
                                   input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == THRESHOLD_ADDR) threshold = value[15:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= THRESHOLD_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== {16'h0, threshold}) begin
      $error("pickup_threshold: expected %0d, actual %0d", threshold, readback);
      fail_count++;
    end
  endtask

  // Receiver: stall a random number of cycles before each transfer
  initial begin
    int stall;
    wait (!rst);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  always @(posedge clk) begin
    mapped_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_maps.size() == 0) begin
        $error("unexpected result transfer: %h", m_tdata);
        fail_count++;
      end else begin
        want = pending_maps.pop_front();
        if (m_tdata[1:0] !== want.mode) begin
          $error("mode: expected %0d, actual %0d", want.mode, m_tdata[1:0]);
          fail_count++;
        end
        if (m_tdata[18:2] !== want.wet) begin
          $error("wet_level: expected %0d, actual %0d", want.wet, m_tdata[18:2]);
          fail_count++;
        end
        if (m_tdata[35:19] !== want.dry) begin
          $error("dry_level: expected %0d, actual %0d", want.dry, m_tdata[35:19]);
          fail_count++;
        end
        if (m_tdata[51:36] !== want.direction) begin
          $error("direction_value: expected %0d, actual %0d", want.direction,
                 m_tdata[51:36]);
          fail_count++;
        end
        if (m_tdata[68:52] !== want.volume) begin
          $error("play_level: expected %0d, actual %0d", want.volume,
                 m_tdata[68:52]);
          fail_count++;
        end
        if (m_tdata[84:69] !== want.decay) begin
          $error("decay_level: expected %0d, actual %0d", want.decay, m_tdata[84:69]);
          fail_count++;
        end
      end
    end
  end

  // up, down, decay, volume, direction, mix | typed | mode, wet, dry, dir, volume, decay
  frame_row_t directed_rows [18] = '{
    // first frame after reset answers held zeros
    '{'{1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
      '{MODE_UP, 17'd0, 17'd0, 16'd0, 17'd0, 16'd0}},
    '{'{1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{MODE_UP, 17'd65536, 17'd2, 16'd65535, 17'd65534, 16'd65535}},
    // mode change: lock all and hold the previous outputs
    '{'{1'b0, 1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000}, 1'b1,
      '{MODE_DOWN, 17'd65536, 17'd2, 16'd65535, 17'd65534, 16'd65535}},
    // exactly at threshold stays locked, one past unlocks
    '{'{1'b0, 1'b1, 16'h828F, 16'h828F, 16'h828F, 16'h828F}, 1'b0, '0},
    '{'{1'b0, 1'b1, 16'h8290, 16'h8290, 16'h8290, 16'h8290}, 1'b0, '0},
    '{'{1'b0, 1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000}, 1'b0, '0},
    '{'{1'b0, 1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0, '0},
    // both switches: up wins
    '{'{1'b1, 1'b1, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0}, 1'b0, '0},
    '{'{1'b1, 1'b0, 16'h1300, 16'h5600, 16'h9B00, 16'hDE00}, 1'b0, '0},
    '{'{1'b0, 1'b0, 16'h4000, 16'h4000, 16'h4000, 16'h4000}, 1'b0, '0},
    // middle: move one pot at a time
    '{'{1'b0, 1'b0, 16'h4000, 16'h4000, 16'h4000, 16'hC000}, 1'b0, '0},
    '{'{1'b0, 1'b0, 16'h4000, 16'h0000, 16'h4000, 16'hC000}, 1'b0, '0},
    '{'{1'b0, 1'b0, 16'h4000, 16'h0000, 16'hFFFF, 16'hC000}, 1'b0, '0},
    '{'{1'b0, 1'b0, 16'h0001, 16'h0000, 16'hFFFF, 16'hC000}, 1'b0, '0},
    // return to down: fresh stash for that mode
    '{'{1'b0, 1'b1, 16'h2000, 16'h6000, 16'hA000, 16'hE000}, 1'b0, '0},
    '{'{1'b0, 1'b1, 16'h1D70, 16'h5D70, 16'h9D70, 16'hDD70}, 1'b0, '0},
    '{'{1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0}
  };

  initial begin
    logic [15:0] level;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_frame(directed_rows[i].f, directed_rows[i].typed, directed_rows[i].want);
    settle();
    // write to an unmapped address must leave the threshold alone
    program_threshold(UNMAPPED_ADDR, 32'h0000_0000);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       level = 16'd0;
        1:       level = 16'd65535;
        2:       level = 16'd1;
        3:       level = THRESHOLD_RESET;
        default: level = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                     : 16'($urandom_range(0, 3000));
      endcase
      settle();
      no_gaps = (phase % 4 == 3);
      program_threshold(THRESHOLD_ADDR, {16'h0, level});
      repeat (PHASE_FRAMES) send_frame(random_frame(), 1'b0, '0);
    end
    settle();

    if (fail_count == 0)
      $display("per_mode_pot_pickup_mapper_core_tb OK");
    else
      $display("per_mode_pot_pickup_mapper_core_tb NOT OK");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("per_mode_pot_pickup_mapper_core_tb NOT OK");
    $finish;
  end

endmodule
